// ----- rtl/core/cat_pkg.sv -----
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and constants for the compacting array table: commands,
// status codes, sequencer states and the request and response items.
// ----------------------------------------------------------------------------
`default_nettype none

package cat_pkg;

   localparam int CAPACITY_DEF = 1024;
   localparam int POS_W        = 10;
   localparam int VAL_W        = 32;
   localparam int FILL_W       = 11;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_READ   = 2'd1,
      CMD_WRITE  = 2'd2,
      CMD_DELETE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RDWAIT,
      S_SEARCH,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic [POS_W-1:0]          position;
      logic signed [VAL_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [VAL_W-1:0]   read_value;
      logic [FILL_W-1:0]         fill_count;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/cat_mem.sv -----
// ----------------------------------------------------------------------------
// cat_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cat_mem #(
   parameter int DEPTH  = cat_pkg::CAPACITY_DEF,
   parameter int ADDR_W = 10
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [cat_pkg::VAL_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic [cat_pkg::VAL_W-1:0]      rd_data
);

   logic [cat_pkg::VAL_W-1:0] mem_ff [DEPTH];
   logic [cat_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/cat_ctrl.sv -----
// ----------------------------------------------------------------------------
// cat_ctrl
// Command sequencer: holds the fill count, runs append, read and write, and
// walks the entry store one entry per cycle for delete (search, then shift).
// ----------------------------------------------------------------------------
`default_nettype none

module cat_ctrl #(
   parameter int CAPACITY = cat_pkg::CAPACITY_DEF,
   parameter int CNT_W    = 11,
   parameter int ADDR_W   = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire cat_pkg::req_type          req_data,
   output logic                           req_ready,
   output logic                           res_valid,
   output cat_pkg::rsp_type               res_data,
   input  wire logic                      res_take,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [cat_pkg::VAL_W-1:0]      wr_data,
   output logic [ADDR_W-1:0]              rd_addr,
   input  wire logic [cat_pkg::VAL_W-1:0] rd_data
);

   localparam int CMP_W = (CNT_W > cat_pkg::POS_W) ? CNT_W : cat_pkg::POS_W;
   localparam int FW    = (CNT_W > cat_pkg::FILL_W) ? CNT_W : cat_pkg::FILL_W;

   cat_pkg::state_type          state_ff, state_in;
   cat_pkg::status_type         status_ff, status_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [cat_pkg::VAL_W-1:0]   val_ff, val_in;
   logic [cat_pkg::VAL_W-1:0]   rdval_ff, rdval_in;

   logic [CNT_W-1:0]            idx_nxt;
   logic [CNT_W-1:0]            idx_prv;
   logic                        last;
   logic [CMP_W-1:0]            pos_ext;
   logic                        in_range;
   logic                        full;
   logic [FW-1:0]               fill_ext;

   assign idx_nxt  = idx_ff + CNT_W'(1);
   assign idx_prv  = idx_ff - CNT_W'(1);
   assign last     = (idx_nxt == count_ff);
   assign pos_ext  = CMP_W'(req_data.position);
   assign in_range = (pos_ext < CMP_W'(count_ff));
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign fill_ext = FW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cat_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      status_in = status_ff;
      rdval_in  = rdval_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[ADDR_W-1:0];
      wr_data   = req_data.value;
      rd_addr   = idx_nxt[ADDR_W-1:0];

      unique case (state_ff)
         cat_pkg::S_IDLE: begin
            if (req_valid) begin
               val_in    = req_data.value;
               rdval_in  = '0;
               status_in = cat_pkg::ST_OK;
               state_in  = cat_pkg::S_DONE;
               unique case (req_data.cmd)
                  cat_pkg::CMD_APPEND: begin
                     if (full) begin
                        status_in = cat_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  cat_pkg::CMD_READ: begin
                     if (!in_range) begin
                        status_in = cat_pkg::ST_RANGE;
                     end else begin
                        rd_addr  = pos_ext[ADDR_W-1:0];
                        state_in = cat_pkg::S_RDWAIT;
                     end
                  end
                  cat_pkg::CMD_WRITE: begin
                     if (!in_range) begin
                        status_in = cat_pkg::ST_RANGE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pos_ext[ADDR_W-1:0];
                     end
                  end
                  cat_pkg::CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = cat_pkg::ST_NOTFOUND;
                     end else begin
                        idx_in   = '0;
                        rd_addr  = '0;
                        state_in = cat_pkg::S_SEARCH;
                     end
                  end
                  default: state_in = cat_pkg::S_DONE;
               endcase
            end
         end

         cat_pkg::S_RDWAIT: begin
            rdval_in = rd_data;
            state_in = cat_pkg::S_DONE;
         end

         // Read of the following entry is always in flight, so a hit starts
         // the shift with its first source word already arriving.
         cat_pkg::S_SEARCH: begin
            if (rd_data == val_ff) begin
               if (last) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = cat_pkg::S_DONE;
               end else begin
                  idx_in   = idx_nxt;
                  state_in = cat_pkg::S_SHIFT;
               end
            end else if (last) begin
               status_in = cat_pkg::ST_NOTFOUND;
               state_in  = cat_pkg::S_DONE;
            end else begin
               idx_in = idx_nxt;
            end
         end

         // Move entry idx down one place.
         cat_pkg::S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_prv[ADDR_W-1:0];
            wr_data = rd_data;
            if (last) begin
               count_in = count_ff - CNT_W'(1);
               state_in = cat_pkg::S_DONE;
            end else begin
               idx_in = idx_nxt;
            end
         end

         cat_pkg::S_DONE: begin
            if (res_take) begin
               state_in = cat_pkg::S_IDLE;
            end
         end

         default: state_in = cat_pkg::S_IDLE;
      endcase
   end

   assign req_ready           = (state_ff == cat_pkg::S_IDLE);
   assign res_valid           = (state_ff == cat_pkg::S_DONE);
   assign res_data.status     = status_ff;
   assign res_data.read_value = rdval_ff;
   assign res_data.fill_count = fill_ext[cat_pkg::FILL_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/compacting_array_table.sv -----
// Append, write and out-of-range commands pass from acceptance through the
// done state into the output register; a read also passes the read-wait
// state, and a delete walks the entries in the search and shift states, one
// entry per cycle through the single read port and compare. A new item is
// taken once the previous one has moved to the output register, which waits
// while the output is stalled. Reset empties the table and the output.
// ----------------------------------------------------------------------------
// compacting_array_table
// Packed array of signed entries with append, read, write and delete of the
// first match; deleted gaps are closed by shifting later entries down.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_array_table #(
   parameter int CAPACITY = cat_pkg::CAPACITY_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cat_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cat_pkg::rsp_type      rsp_data
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                        req_ready;
   logic                        res_valid;
   cat_pkg::rsp_type            res_data;
   logic                        res_take;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [cat_pkg::VAL_W-1:0]   wr_data;
   logic [ADDR_W-1:0]           rd_addr;
   logic [cat_pkg::VAL_W-1:0]   rd_data;

   logic                        rsp_valid_ff, rsp_valid_in;
   cat_pkg::rsp_type            rsp_data_ff;

   cat_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W),
      .ADDR_W   (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_take  (res_take),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   cat_mem #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Load the output register when it is empty or being drained.
   assign res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign req_stall = !req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous one still in work");

   a_value_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != cat_pkg::ST_OK) |-> rsp_data.read_value == '0)
      else $error("read value nonzero on failed command");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 2047) || (int'(rsp_data.fill_count) <= CAPACITY))
      else $error("fill count above capacity");
`endif

endmodule

`default_nettype wire
